// File: rtl/core/line_raster_with_brush_unit_assert.svh
// assertion macros for the line rasterizer with brush
// used by the top level only; no other dependencies
`ifndef LINE_RASTER_WITH_BRUSH_UNIT_ASSERT_SVH
`define LINE_RASTER_WITH_BRUSH_UNIT_ASSERT_SVH
`ifndef SYNTH
// condition must never be seen at a clock edge
`define LRB_ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("lrb: forbidden condition seen");
// antecedent at one edge implies consequent at the next
`define LRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lrb: expected follow-up missing");
`else
`define LRB_ASSERT_NEVER(lbl, clk, rstn, cond)
`define LRB_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/lrb_pkg.sv
// shared types, codes and brush tables for the line rasterizer with brush
// no dependencies
package lrb_pkg;

    // coordinate width and derived widths
    localparam int COORD_BITS    = 12;
    localparam int DIFF_BITS     = COORD_BITS + 1;
    localparam int DEC_BITS      = COORD_BITS + 5;
    localparam int INC_BITS      = COORD_BITS + 4;
    localparam int IN_DATA_BITS  = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    // point queue between front and back
    localparam int PT_FIFO_DEPTH = 4;
    localparam int PT_PTR_BITS   = $clog2(PT_FIFO_DEPTH);
    localparam int PT_CNT_BITS   = $clog2(PT_FIFO_DEPTH + 1);

    // operation codes
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // octant cases
    localparam logic [1:0] OCT_SHALLOW_RISE = 2'd0;
    localparam logic [1:0] OCT_STEEP_RISE   = 2'd1;
    localparam logic [1:0] OCT_SHALLOW_FALL = 2'd2;
    localparam logic [1:0] OCT_STEEP_FALL   = 2'd3;

    // brush codes
    localparam logic [2:0] BRUSH_SINGLE = 3'd0;
    localparam logic [2:0] BRUSH_HPAIR  = 3'd1;
    localparam logic [2:0] BRUSH_VPAIR  = 3'd2;
    localparam logic [2:0] BRUSH_CROSS  = 3'd3;
    localparam logic [2:0] BRUSH_RING   = 3'd4;

    localparam logic signed [1:0] OFS_NEG  = -2'sd1;
    localparam logic signed [1:0] OFS_ZERO = 2'sd0;
    localparam logic signed [1:0] OFS_POS  = 2'sd1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [DEC_BITS-1:0]   dec_t;
    typedef logic signed [INC_BITS-1:0]   inc_t;

    // one line point handed from front to back
    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   done;
    } point_t;

    // number of neighbour pixels of a brush
    function automatic logic [3:0] brush_count(input logic [2:0] p);
        logic [3:0] n;
        case (p)
            BRUSH_HPAIR, BRUSH_VPAIR: n = 4'd2;
            BRUSH_CROSS:              n = 4'd4;
            BRUSH_RING:               n = 4'd8;
            default:                  n = 4'd0;
        endcase
        return n;
    endfunction

    // column offset of neighbour k
    function automatic logic signed [1:0] brush_dx(input logic [2:0] p,
                                                  input logic [2:0] k);
        logic signed [1:0] d;
        d = OFS_ZERO;
        case (p)
            BRUSH_HPAIR: d = (k == 3'd0) ? OFS_NEG : OFS_POS;
            BRUSH_CROSS: begin
                if (k == 3'd2)
                    d = OFS_NEG;
                else if (k == 3'd3)
                    d = OFS_POS;
            end
            BRUSH_RING: begin
                case (k)
                    3'd0, 3'd3, 3'd6: d = OFS_NEG;
                    3'd2, 3'd4, 3'd7: d = OFS_POS;
                    default:          d = OFS_ZERO;
                endcase
            end
            default: d = OFS_ZERO;
        endcase
        return d;
    endfunction

    // row offset of neighbour k
    function automatic logic signed [1:0] brush_dy(input logic [2:0] p,
                                                  input logic [2:0] k);
        logic signed [1:0] d;
        d = OFS_ZERO;
        case (p)
            BRUSH_VPAIR, BRUSH_CROSS: begin
                if (k == 3'd0)
                    d = OFS_NEG;
                else if (k == 3'd1)
                    d = OFS_POS;
            end
            BRUSH_RING: begin
                case (k)
                    3'd0, 3'd1, 3'd2: d = OFS_NEG;
                    3'd5, 3'd6, 3'd7: d = OFS_POS;
                    default:          d = OFS_ZERO;
                endcase
            end
            default: d = OFS_ZERO;
        endcase
        return d;
    endfunction

endpackage

// File: rtl/core/lrb_front.sv
// front part: accepts items, sets up lines and steps the midpoint loop
// depends on lrb_pkg
module lrb_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             in_operation,
    input  lrb_pkg::coord_t                  in_x_start,
    input  lrb_pkg::coord_t                  in_y_start,
    input  lrb_pkg::coord_t                  in_x_end,
    input  lrb_pkg::coord_t                  in_y_end,
    input  logic                             pt_full,
    output logic                             pt_push,
    output lrb_pkg::point_t                  pt_data
);

    localparam int C  = lrb_pkg::COORD_BITS;
    localparam int DB = lrb_pkg::DEC_BITS;
    localparam int IB = lrb_pkg::INC_BITS;

    // control state
    logic       pend_reg, pend_next;
    logic       active_reg, active_next;
    logic [1:0] oct_reg, oct_next;

    // line state
    lrb_pkg::coord_t px_reg, px_next, py_reg, py_next;
    lrb_pkg::coord_t stopx_reg, stopx_next, stopy_reg, stopy_next;
    lrb_pkg::dec_t   dec_reg, dec_next;
    lrb_pkg::inc_t   sinc_reg, sinc_next, dinc_reg, dinc_next;

    // setup stage of a start item
    lrb_pkg::coord_t sx0_reg, sx0_next, sy0_reg, sy0_next;
    lrb_pkg::coord_t sx1_reg, sx1_next, sy1_reg, sy1_next;
    lrb_pkg::diff_t  dx_reg, dx_next, dy_reg, dy_next;

    logic accept;
    logic swap;

    // classify terms
    lrb_pkg::diff_t ady;
    lrb_pkg::dec_t  dxe, dye, dx2, dy2;
    lrb_pkg::dec_t  c_dec, c_sinc, c_dinc;
    logic [1:0]     c_oct;

    // step terms
    logic            straight;
    logic            step_x, step_y;
    lrb_pkg::coord_t nx, ny;
    lrb_pkg::dec_t   inc_sel;

    assign in_ready = !pt_full && !pend_reg;
    assign accept   = in_valid && in_ready;
    assign swap     = in_x_start > in_x_end;

    // octant selection from the registered differences
    always_comb begin
        ady = dy_reg[C] ? -dy_reg : dy_reg;
        dxe = {{(DB-C-1){dx_reg[C]}}, dx_reg};
        dye = {{(DB-C-1){dy_reg[C]}}, dy_reg};
        dx2 = dxe + dxe;
        dy2 = dye + dye;
        if (!dy_reg[C] && dx_reg >= ady) begin
            c_oct  = lrb_pkg::OCT_SHALLOW_RISE;
            c_dec  = dy2 - dxe;
            c_sinc = dy2;
            c_dinc = dy2 - dx2;
        end else if (!dy_reg[C]) begin
            c_oct  = lrb_pkg::OCT_STEEP_RISE;
            c_dec  = dye - dx2;
            c_sinc = -dx2;
            c_dinc = dy2 - dx2;
        end else if (dx_reg >= ady) begin
            c_oct  = lrb_pkg::OCT_SHALLOW_FALL;
            c_dec  = dy2 + dxe;
            c_sinc = dy2;
            c_dinc = dy2 + dx2;
        end else begin
            c_oct  = lrb_pkg::OCT_STEEP_FALL;
            c_dec  = dye + dx2;
            c_sinc = dx2;
            c_dinc = dx2 + dy2;
        end
    end

    // one midpoint step with the tie rule of each octant
    always_comb begin
        case (oct_reg)
            lrb_pkg::OCT_SHALLOW_RISE: begin
                straight = (dec_reg <= 0);
                step_x   = 1'b1;
                step_y   = !straight;
            end
            lrb_pkg::OCT_STEEP_RISE: begin
                straight = (dec_reg > 0);
                step_x   = !straight;
                step_y   = 1'b1;
            end
            lrb_pkg::OCT_SHALLOW_FALL: begin
                straight = (dec_reg > 0);
                step_x   = 1'b1;
                step_y   = !straight;
            end
            default: begin
                straight = (dec_reg < 0);
                step_x   = !straight;
                step_y   = 1'b1;
            end
        endcase
        inc_sel = straight ? {{(DB-IB){sinc_reg[IB-1]}}, sinc_reg}
                           : {{(DB-IB){dinc_reg[IB-1]}}, dinc_reg};
        nx = px_reg + lrb_pkg::coord_t'(step_x);
        ny = oct_reg[1] ? py_reg - lrb_pkg::coord_t'(step_y)
                        : py_reg + lrb_pkg::coord_t'(step_y);
    end

    // item handling
    always_comb begin
        pend_next   = pend_reg;
        active_next = active_reg;
        oct_next    = oct_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        stopx_next  = stopx_reg;
        stopy_next  = stopy_reg;
        dec_next    = dec_reg;
        sinc_next   = sinc_reg;
        dinc_next   = dinc_reg;
        sx0_next    = sx0_reg;
        sy0_next    = sy0_reg;
        sx1_next    = sx1_reg;
        sy1_next    = sy1_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        pt_push     = 1'b0;
        pt_data     = '{x: px_reg, y: py_reg, done: 1'b0};
        if (pend_reg) begin
            // setup step of a start: load the line and emit its first point
            pend_next   = 1'b0;
            oct_next    = c_oct;
            dec_next    = c_dec;
            sinc_next   = c_sinc[IB-1:0];
            dinc_next   = c_dinc[IB-1:0];
            px_next     = sx0_reg;
            py_next     = sy0_reg;
            stopx_next  = sx1_reg;
            stopy_next  = sy1_reg;
            pt_push     = 1'b1;
            pt_data.x   = sx0_reg;
            pt_data.y   = sy0_reg;
            pt_data.done = c_oct[0] ? (sy0_reg == sy1_reg) : (sx0_reg == sx1_reg);
            active_next = !pt_data.done;
        end else if (accept) begin
            if (in_operation == lrb_pkg::OP_START) begin
                // ordering step of a start: order endpoints so x rises
                pend_next = 1'b1;
                sx0_next  = swap ? in_x_end   : in_x_start;
                sy0_next  = swap ? in_y_end   : in_y_start;
                sx1_next  = swap ? in_x_start : in_x_end;
                sy1_next  = swap ? in_y_start : in_y_end;
                dx_next   = swap ? {in_x_start[C-1], in_x_start} - {in_x_end[C-1], in_x_end}
                                 : {in_x_end[C-1], in_x_end} - {in_x_start[C-1], in_x_start};
                dy_next   = swap ? {in_y_start[C-1], in_y_start} - {in_y_end[C-1], in_y_end}
                                 : {in_y_end[C-1], in_y_end} - {in_y_start[C-1], in_y_start};
            end else if (active_reg) begin
                // advance: one step and emit the new point
                dec_next     = dec_reg + inc_sel;
                px_next      = nx;
                py_next      = ny;
                pt_push      = 1'b1;
                pt_data.x    = nx;
                pt_data.y    = ny;
                pt_data.done = oct_reg[0] ? (ny == stopy_reg) : (nx == stopx_reg);
                active_next  = !pt_data.done;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg   <= 1'b0;
            active_reg <= 1'b0;
            oct_reg    <= lrb_pkg::OCT_SHALLOW_RISE;
        end else begin
            pend_reg   <= pend_next;
            active_reg <= active_next;
            oct_reg    <= oct_next;
        end
    end

    // line and setup payload
    always_ff @(posedge aclk) begin
        px_reg    <= px_next;
        py_reg    <= py_next;
        stopx_reg <= stopx_next;
        stopy_reg <= stopy_next;
        dec_reg   <= dec_next;
        sinc_reg  <= sinc_next;
        dinc_reg  <= dinc_next;
        sx0_reg   <= sx0_next;
        sy0_reg   <= sy0_next;
        sx1_reg   <= sx1_next;
        sy1_reg   <= sy1_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
    end

endmodule

// File: rtl/core/lrb_point_fifo.sv
// small register queue of line points between front and back
// depends on lrb_pkg
module lrb_point_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lrb_pkg::point_t push_data,
    output logic            full,
    input  logic            pop,
    output lrb_pkg::point_t head,
    output logic            empty
);

    localparam int PB = lrb_pkg::PT_PTR_BITS;
    localparam int CB = lrb_pkg::PT_CNT_BITS;

    lrb_pkg::point_t entry_reg [lrb_pkg::PT_FIFO_DEPTH];

    logic [PB-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PB-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CB-1:0] count_reg, count_next;

    assign full  = (count_reg == CB'(lrb_pkg::PT_FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill count update, wrapping at the depth
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PB'(lrb_pkg::PT_FIFO_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PB'(lrb_pkg::PT_FIFO_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// File: rtl/core/lrb_brush_back.sv
// back part: expands each queued point into brush pixels, one per unstalled cycle
// depends on lrb_pkg
module lrb_brush_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [2:0]      brush_pattern,
    input  lrb_pkg::point_t pt_head,
    input  logic            pt_empty,
    output logic            pt_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output lrb_pkg::coord_t out_x,
    output lrb_pkg::coord_t out_y,
    output logic            out_last,
    output logic            out_done
);

    localparam int C = lrb_pkg::COORD_BITS;

    // current point and neighbour index
    logic            cur_valid_reg, cur_valid_next;
    lrb_pkg::point_t cur_reg, cur_next;
    logic [3:0]      k_reg, k_next;

    // output register
    logic            ovalid_reg, ovalid_next;
    lrb_pkg::coord_t ox_reg, ox_next, oy_reg, oy_next;
    logic            olast_reg, olast_next, odone_reg, odone_next;

    logic [2:0]        pat;
    logic [3:0]        n;
    logic              load, centre;
    logic signed [1:0] ofs_x, ofs_y;

    assign pat    = (brush_pattern <= lrb_pkg::BRUSH_RING) ? brush_pattern
                                                           : lrb_pkg::BRUSH_SINGLE;
    assign n      = lrb_pkg::brush_count(pat);
    assign ofs_x  = lrb_pkg::brush_dx(pat, k_reg[2:0]);
    assign ofs_y  = lrb_pkg::brush_dy(pat, k_reg[2:0]);
    assign load   = cur_valid_reg && (!ovalid_reg || out_ready);
    assign centre = (k_reg == n);
    assign pt_pop = !pt_empty && (!cur_valid_reg || (load && centre));

    assign out_valid = ovalid_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_last  = olast_reg;
    assign out_done  = odone_reg;

    // pixel sequencing: neighbours in table order, then the centre
    always_comb begin
        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        ovalid_next    = ovalid_reg && !out_ready;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        olast_next     = olast_reg;
        odone_next     = odone_reg;
        if (load) begin
            ovalid_next = 1'b1;
            odone_next  = cur_reg.done;
            if (centre) begin
                ox_next        = cur_reg.x;
                oy_next        = cur_reg.y;
                olast_next     = 1'b1;
                k_next         = '0;
                cur_valid_next = 1'b0;
            end else begin
                ox_next    = cur_reg.x + {{(C-2){ofs_x[1]}}, ofs_x};
                oy_next    = cur_reg.y + {{(C-2){ofs_y[1]}}, ofs_y};
                olast_next = 1'b0;
                k_next     = k_reg + 1'b1;
            end
        end
        if (pt_pop) begin
            cur_valid_next = 1'b1;
            cur_next       = pt_head;
            k_next         = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            k_reg         <= '0;
            ovalid_reg    <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            k_reg         <= k_next;
            ovalid_reg    <= ovalid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        cur_reg   <= cur_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        olast_reg <= olast_next;
        odone_reg <= odone_next;
    end

endmodule

// File: rtl/core/line_raster_with_brush_unit.sv
// top level of the line rasterizer with brush
// depends on lrb_pkg, lrb_front, lrb_point_fifo, lrb_brush_back and the assert header

// Midpoint line rasterizer with a brush. A start item (tuser 0) loads two
// endpoints and gives the first point; each advance item (tuser 1) gives the
// next point, and an advance with no line running gives nothing. Every point
// leaves as a run of pixels: the brush neighbours in fixed order, then the
// centre with tlast set; tuser carries line_done on every pixel of the final
// point. The front handles a start item as endpoint ordering, then octant
// setup; it then drops each point into a four-entry queue. The brush
// expander behind the queue sends one pixel per cycle while m_tready holds,
// so a point gives 1, 3, 5 or 9 pixels for brush single, pair, cross or
// full ring, and the result port sets the sustained rate. The input accepts
// while the queue has room and no start is in setup. The brush register
// must only be written while no run is in flight.
module line_raster_with_brush_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [2:0]                        cfg_wdata,    // brush_pattern
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [lrb_pkg::IN_DATA_BITS-1:0]  s_tdata,      // x_start, y_start, x_end, y_end
    input  logic [0:0]                        s_tuser,      // operation
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [lrb_pkg::OUT_DATA_BITS-1:0] m_tdata,      // pixel_x, pixel_y
    output logic                              m_tlast,      // run_last
    output logic [0:0]                        m_tuser       // line_done
);

`include "line_raster_with_brush_unit_assert.svh"

    localparam int C = lrb_pkg::COORD_BITS;

    logic [2:0] brush_reg;

    logic            pt_push, pt_full, pt_pop, pt_empty;
    lrb_pkg::point_t pt_in, pt_head;

    lrb_pkg::coord_t pix_x, pix_y;
    logic            pix_done;

    logic            start_taken;

    // brush register
    always_ff @(posedge aclk) begin
        if (!aresetn)
            brush_reg <= lrb_pkg::BRUSH_SINGLE;
        else if (cfg_we)
            brush_reg <= cfg_wdata;
    end

    // front: item intake and line stepping
    lrb_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .in_operation (s_tuser[0]),
        .in_x_start   (s_tdata[C-1:0]),
        .in_y_start   (s_tdata[2*C-1:C]),
        .in_x_end     (s_tdata[3*C-1:2*C]),
        .in_y_end     (s_tdata[4*C-1:3*C]),
        .pt_full      (pt_full),
        .pt_push      (pt_push),
        .pt_data      (pt_in)
    );

    // point queue
    lrb_point_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pt_push),
        .push_data (pt_in),
        .full      (pt_full),
        .pop       (pt_pop),
        .head      (pt_head),
        .empty     (pt_empty)
    );

    // back: brush expansion
    lrb_brush_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .brush_pattern (brush_reg),
        .pt_head       (pt_head),
        .pt_empty      (pt_empty),
        .pt_pop        (pt_pop),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_x         (pix_x),
        .out_y         (pix_y),
        .out_last      (m_tlast),
        .out_done      (pix_done)
    );

    // result packing
    assign m_tdata    = lrb_pkg::OUT_DATA_BITS'({pix_y, pix_x});
    assign m_tuser[0] = pix_done;

    // checks
    assign start_taken = s_tvalid && s_tready && (s_tuser[0] == lrb_pkg::OP_START);

    `LRB_ASSERT_NEVER(a_fifo_no_overflow, aclk, aresetn, pt_push && pt_full)
    `LRB_ASSERT_NEVER(a_fifo_no_underflow, aclk, aresetn, pt_pop && pt_empty)
    `LRB_ASSERT_NEXT(a_start_blocks_intake, aclk, aresetn, start_taken, !s_tready)
    `LRB_ASSERT_NEXT(a_run_continues, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule
